// File: src/ffs_pkg.sv
package ffs_pkg;

  localparam int unsigned CntWidth = 16;
  localparam logic [CntWidth-1:0] CntMax = '1;

  // Fault codes
  localparam logic [2:0] FAULT_NONE    = 3'd0;
  localparam logic [2:0] FAULT_BATTERY = 3'd1;
  localparam logic [2:0] FAULT_TILT    = 3'd2;
  localparam logic [2:0] FAULT_DUTY    = 3'd3;
  localparam logic [2:0] FAULT_SIGNAL  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_BATTERY_LOW_LEVEL  = 3'd0;
  localparam logic [2:0] REG_BATTERY_TRIP_TICKS = 3'd1;
  localparam logic [2:0] REG_TILT_LIMIT         = 3'd2;
  localparam logic [2:0] REG_TILT_TRIP_TICKS    = 3'd3;
  localparam logic [2:0] REG_DUTY_HIGH_LEVEL    = 3'd4;
  localparam logic [2:0] REG_DUTY_TRIP_TICKS    = 3'd5;
  localparam logic [2:0] REG_SIGNAL_LOSS_TICKS  = 3'd6;

  // Reset values of the configuration registers
  localparam logic [9:0]  RstBatteryLowLevel  = 10'd37;
  localparam logic [15:0] RstBatteryTripTicks = 16'd300;
  localparam logic [14:0] RstTiltLimit        = 15'd8000;
  localparam logic [15:0] RstTiltTripTicks    = 16'd10;
  localparam logic [15:0] RstDutyHighLevel    = 16'd9900;
  localparam logic [15:0] RstDutyTripTicks    = 16'd20;
  localparam logic [15:0] RstSignalLossTicks  = 16'd20;

  typedef struct packed {
    logic [9:0]         batt_level;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic [15:0]        duty_front_a;
    logic [15:0]        duty_front_b;
    logic [15:0]        duty_rear_a;
    logic [15:0]        duty_rear_b;
    logic               frame_seen;
  } ffs_tick_t;

  typedef struct packed {
    logic [2:0] fault_code;
    logic       motors_enabled;
  } ffs_result_t;

  typedef struct packed {
    logic [9:0]  battery_low_level;
    logic [15:0] battery_trip_ticks;
    logic [14:0] tilt_limit;
    logic [15:0] tilt_trip_ticks;
    logic [15:0] duty_high_level;
    logic [15:0] duty_trip_ticks;
    logic [15:0] signal_loss_ticks;
  } ffs_cfg_t;

  typedef struct packed {
    logic [CntWidth-1:0] battery_low_count;
    logic [CntWidth-1:0] tilt_count;
    logic [CntWidth-1:0] duty_high_count;
    logic [CntWidth-1:0] signal_loss_count;
    logic                frame_pending;
  } ffs_state_t;

  function automatic logic [CntWidth-1:0] sat_inc(input logic [CntWidth-1:0] c);
    return (c == CntMax) ? c : c + 1'b1;
  endfunction

  // |x| of a 16-bit two's complement value; -32768 gives 32768.
  function automatic logic [16:0] magnitude16(input logic signed [15:0] v);
    return v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
  endfunction

endpackage

// File: src/ffs_eval.sv
module ffs_eval (
  input  ffs_pkg::ffs_cfg_t    cfg,
  input  ffs_pkg::ffs_state_t  state,
  input  ffs_pkg::ffs_tick_t   tick,
  output ffs_pkg::ffs_state_t  state_next,
  output ffs_pkg::ffs_result_t result
);
  import ffs_pkg::*;

  logic                battery_cond, tilt_cond, duty_cond, pending;
  logic                battery_trip, tilt_trip, duty_trip, signal_trip;
  logic [CntWidth-1:0] battery_cnt, tilt_cnt, duty_cnt, signal_cnt;
  logic [16:0]         roll_mag, pitch_mag, limit_ext;

  assign roll_mag  = magnitude16(tick.roll_angle);
  assign pitch_mag = magnitude16(tick.pitch_angle);
  assign limit_ext = {2'b00, cfg.tilt_limit};

  assign battery_cond = tick.batt_level < cfg.battery_low_level;
  assign tilt_cond    = (roll_mag > limit_ext) || (pitch_mag > limit_ext);
  assign duty_cond    = (tick.duty_front_a >= cfg.duty_high_level) ||
                        (tick.duty_front_b >= cfg.duty_high_level) ||
                        (tick.duty_rear_a  >= cfg.duty_high_level) ||
                        (tick.duty_rear_b  >= cfg.duty_high_level);
  assign pending      = state.frame_pending | tick.frame_seen;

  assign battery_cnt  = battery_cond ? sat_inc(state.battery_low_count) : '0;
  assign tilt_cnt     = tilt_cond ? sat_inc(state.tilt_count) : '0;
  assign duty_cnt     = duty_cond ? sat_inc(state.duty_high_count) : '0;
  assign signal_cnt   = pending ? '0 : sat_inc(state.signal_loss_count);

  assign battery_trip = battery_cond && (battery_cnt >= cfg.battery_trip_ticks);
  assign tilt_trip    = tilt_cond && (tilt_cnt >= cfg.tilt_trip_ticks);
  assign duty_trip    = duty_cond && (duty_cnt >= cfg.duty_trip_ticks);
  assign signal_trip  = !pending && (signal_cnt > cfg.signal_loss_ticks);

  // Checks after the first trip are skipped and keep their state.
  always_comb begin
    state_next = state;
    result.fault_code = FAULT_NONE;
    state_next.battery_low_count = battery_cnt;
    if (battery_trip) begin
      result.fault_code = FAULT_BATTERY;
      state_next.frame_pending = pending;
    end else begin
      state_next.tilt_count = tilt_cnt;
      if (tilt_trip) begin
        result.fault_code = FAULT_TILT;
        state_next.frame_pending = pending;
      end else begin
        state_next.duty_high_count = duty_cnt;
        if (duty_trip) begin
          result.fault_code = FAULT_DUTY;
          state_next.frame_pending = pending;
        end else begin
          state_next.signal_loss_count = signal_cnt;
          state_next.frame_pending = 1'b0;
          if (signal_trip) begin
            result.fault_code = FAULT_SIGNAL;
          end
        end
      end
    end
    result.motors_enabled = (result.fault_code == FAULT_NONE);
  end

endmodule

// File: src/flight_fault_supervisor.sv
// Flight fault supervisor.
// Tick channel: tick_valid / tick_stall / tick carry one supervision tick
// (battery voltage, roll and pitch, four motor duties, remote frame flag).
// Result channel: result_valid / result_stall / result carry the fault code
// and the motor enable for that tick. A transaction completes at a rising
// edge with valid high and stall low; exactly one result per tick.
// Path: a taken tick waits in the stage register; its result is loaded into
// the result register when the stage moves on. Throughput is one tick per
// cycle while the receiver does not stall; one pass of compares and counter
// updates lies between the stage register and the result register.
// When the receiver stalls, the result holds and the stage register keeps
// the next tick, so one more transaction is taken before tick_stall rises.
// Configuration: cfg_we writes cfg_data into register cfg_index (indexes
// beyond the list are ignored); write only while the block is idle.
// Reset (rst, synchronous): configuration returns to its defaults, the four
// persistence counters and the pending frame latch clear, both stages empty.
module flight_fault_supervisor (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick_valid,
  output logic                   tick_stall,
  input  ffs_pkg::ffs_tick_t     tick,
  output logic                   result_valid,
  input  logic                   result_stall,
  output ffs_pkg::ffs_result_t   result,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data
);
  import ffs_pkg::*;

  ffs_cfg_t    cfg;
  ffs_state_t  state, state_next;
  ffs_tick_t   stage;
  logic        stage_valid;
  logic        advance;
  ffs_result_t result_next;

  // Stage moves on when the result register is empty or being drained.
  assign advance    = stage_valid && (!result_valid || !result_stall);
  assign tick_stall = stage_valid && !advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.battery_low_level  <= RstBatteryLowLevel;
      cfg.battery_trip_ticks <= RstBatteryTripTicks;
      cfg.tilt_limit         <= RstTiltLimit;
      cfg.tilt_trip_ticks    <= RstTiltTripTicks;
      cfg.duty_high_level    <= RstDutyHighLevel;
      cfg.duty_trip_ticks    <= RstDutyTripTicks;
      cfg.signal_loss_ticks  <= RstSignalLossTicks;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BATTERY_LOW_LEVEL:  cfg.battery_low_level  <= cfg_data[9:0];
        REG_BATTERY_TRIP_TICKS: cfg.battery_trip_ticks <= cfg_data;
        REG_TILT_LIMIT:         cfg.tilt_limit         <= cfg_data[14:0];
        REG_TILT_TRIP_TICKS:    cfg.tilt_trip_ticks    <= cfg_data;
        REG_DUTY_HIGH_LEVEL:    cfg.duty_high_level    <= cfg_data;
        REG_DUTY_TRIP_TICKS:    cfg.duty_trip_ticks    <= cfg_data;
        REG_SIGNAL_LOSS_TICKS:  cfg.signal_loss_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!tick_stall) begin
      stage_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!tick_stall && tick_valid) begin
      stage <= tick;
    end
  end

  ffs_eval u_eval (
    .cfg        (cfg),
    .state      (state),
    .tick       (stage),
    .state_next (state_next),
    .result     (result_next)
  );

  // Persistence counters and frame latch
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

`ifndef ASSERT_OFF
  a_enable_matches_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.motors_enabled == (result.fault_code == FAULT_NONE)))
    else $error("motor enable disagrees with fault code");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.fault_code <= FAULT_SIGNAL))
    else $error("fault code out of range");

  a_stall_needs_stage: assert property (@(posedge clk) disable iff (rst)
    tick_stall |-> (stage_valid && result_valid && result_stall))
    else $error("tick stalled without a blocked stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    tick_stall |=> (stage_valid && $stable(stage) && $stable(state)))
    else $error("stage or state changed while blocked");

  a_result_from_advance: assert property (@(posedge clk) disable iff (rst)
    (!result_valid && !advance) |=> !result_valid)
    else $error("result appeared without a stage transfer");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

// Bench for the flight fault supervisor.
// A predictor of the supervisor runs next to the block: every tick transaction
// that the block takes is run through it, and the fault it predicts is queued.
// Each result transaction is checked against the oldest queued fault.
module tb_top;
  import ffs_pkg::*;

  // No register sits at this index; a write there must be dropped.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  localparam int HOLD_CYCLES = 150;   // long receiver hold-off
  localparam int IDLE_LIMIT  = 4000;  // cycles with no transaction at all
  localparam int MAX_SHOWN   = 10;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         tick_valid = 1'b0;
  logic         tick_stall;
  ffs_tick_t    tick = '0;
  logic         result_valid;
  logic         result_stall = 1'b1;
  ffs_result_t  result;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = REG_BATTERY_LOW_LEVEL;
  logic [15:0]  cfg_data = '0;

  // Idle rates in percent, changed per phase.
  int send_idle_pct = 23;
  int recv_idle_pct = 85;

  // Hold-off request: the main thread bumps the request id, the stall
  // process sees it and stalls while hold_left counts down from HOLD_CYCLES.
  int hold_req_id  = 0;
  int hold_seen_id = 0;
  int hold_left    = 0;

  int fail_count  = 0;
  int idle_cycles = 0;

  // Predictor state: configuration, persistence counters, frame latch.
  ffs_cfg_t    model_cfg;
  logic [15:0] batt_low_cnt = '0;
  logic [15:0] tilt_cnt     = '0;
  logic [15:0] duty_cnt     = '0;
  logic [15:0] loss_cnt     = '0;
  logic        frame_latched = 1'b0;

  ffs_result_t expected_faults[$];
  ffs_result_t want;

  flight_fault_supervisor dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic [15:0] sat_bump(input logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  // One supervision tick. Checks run battery, tilt, duty, signal; the first
  // one that trips ends the tick and the later ones leave their counters.
  function automatic ffs_result_t predict_fault(input ffs_tick_t t);
    logic [16:0] roll_mag;
    logic [16:0] pitch_mag;
    logic [15:0] lvl;
    logic [2:0]  code;
    ffs_result_t r;
    // |angle| on 17 bits so that -32768 keeps its full magnitude
    roll_mag  = t.roll_angle[15] ? 17'h10000 - {1'b0, t.roll_angle} : {1'b0, t.roll_angle};
    pitch_mag = t.pitch_angle[15] ? 17'h10000 - {1'b0, t.pitch_angle}
                                  : {1'b0, t.pitch_angle};
    lvl  = model_cfg.duty_high_level;
    code = FAULT_NONE;
    // a frame is latched even when the signal check does not run this tick
    if (t.frame_seen) frame_latched = 1'b1;

    if (t.batt_level < model_cfg.battery_low_level) begin
      batt_low_cnt = sat_bump(batt_low_cnt);
      if (batt_low_cnt >= model_cfg.battery_trip_ticks) code = FAULT_BATTERY;
    end else begin
      batt_low_cnt = '0;
    end

    if (code == FAULT_NONE) begin
      if (roll_mag > {2'b00, model_cfg.tilt_limit} ||
          pitch_mag > {2'b00, model_cfg.tilt_limit}) begin
        tilt_cnt = sat_bump(tilt_cnt);
        if (tilt_cnt >= model_cfg.tilt_trip_ticks) code = FAULT_TILT;
      end else begin
        tilt_cnt = '0;
      end
    end

    if (code == FAULT_NONE) begin
      if (t.duty_front_a >= lvl || t.duty_front_b >= lvl ||
          t.duty_rear_a >= lvl || t.duty_rear_b >= lvl) begin
        duty_cnt = sat_bump(duty_cnt);
        if (duty_cnt >= model_cfg.duty_trip_ticks) code = FAULT_DUTY;
      end else begin
        duty_cnt = '0;
      end
    end

    // strict compare: a limit of 65535 can never be passed by a saturated count
    if (code == FAULT_NONE) begin
      if (frame_latched) begin
        frame_latched = 1'b0;
        loss_cnt = '0;
      end else begin
        loss_cnt = sat_bump(loss_cnt);
        if (loss_cnt > model_cfg.signal_loss_ticks) code = FAULT_SIGNAL;
      end
    end

    r.fault_code     = code;
    r.motors_enabled = (code == FAULT_NONE);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic ffs_tick_t mk_tick(input int volt, input int roll, input int pitch,
                                        input int d0, input int d1, input int d2,
                                        input int d3, input bit frame);
    ffs_tick_t t;
    t.batt_level   = 10'(volt);
    t.roll_angle   = 16'(roll);
    t.pitch_angle  = 16'(pitch);
    t.duty_front_a = 16'(d0);
    t.duty_front_b = 16'(d1);
    t.duty_rear_a  = 16'(d2);
    t.duty_rear_b  = 16'(d3);
    t.frame_seen   = frame;
    return t;
  endfunction

  function automatic logic signed [15:0] to_angle(input int mag, input bit neg);
    if (mag >= 32768) return 16'sh8000;
    return neg ? 16'(-mag) : 16'(mag);
  endfunction

  // Tick placed around the current thresholds: each flag pushes its check
  // over the line, a clear flag keeps it under. One tick in ten is raw noise.
  function automatic ffs_tick_t random_tick(input bit low, input bit tilt, input bit sat,
                                            input int frame_pct);
    ffs_tick_t   t;
    logic [31:0] r0;
    logic [31:0] r1;
    int          lvl;
    int          volt;
    int          roll_mag;
    int          pitch_mag;
    int          hot;
    int          duty[4];
    int          i;
    r0 = $urandom;
    r1 = $urandom;
    if ($urandom_range(9) == 0) begin
      t.batt_level   = r0[9:0];
      t.roll_angle   = r0[31:16];
      t.pitch_angle  = r1[15:0];
      t.duty_front_a = r1[31:16];
      r0 = $urandom;
      r1 = $urandom;
      t.duty_front_b = r0[15:0];
      t.duty_rear_a  = r0[31:16];
      t.duty_rear_b  = r1[15:0];
      t.frame_seen   = r1[16];
      return t;
    end

    lvl = int'(model_cfg.battery_low_level);
    if (low && lvl > 0) volt = ($urandom_range(1) == 0) ? lvl - 1 : $urandom_range(lvl - 1, 0);
    else if (!low) volt = ($urandom_range(1) == 0) ? lvl : $urandom_range(1023, lvl);
    else volt = $urandom_range(1023, 0);
    t.batt_level = 10'(volt);

    lvl = int'(model_cfg.tilt_limit);
    roll_mag  = $urandom_range(lvl, 0);
    pitch_mag = $urandom_range(lvl, 0);
    if ($urandom_range(3) == 0) roll_mag = lvl;
    if (tilt) begin
      hot = lvl + 1 + (($urandom_range(1) == 0) ? 0 : $urandom_range(3000, 0));
      case ($urandom_range(2))
        0: roll_mag = hot;
        1: pitch_mag = hot;
        default: begin
          roll_mag  = hot;
          pitch_mag = hot;
        end
      endcase
    end
    t.roll_angle  = to_angle(roll_mag, $urandom_range(1) == 0);
    t.pitch_angle = to_angle(pitch_mag, $urandom_range(1) == 0);

    lvl = int'(model_cfg.duty_high_level);
    for (i = 0; i < 4; i++) begin
      duty[i] = (lvl == 0) ? $urandom_range(65535, 0) : $urandom_range(lvl - 1, 0);
    end
    if (sat) begin
      hot = ($urandom_range(1) == 0) ? lvl : $urandom_range(65535, lvl);
      if ($urandom_range(3) == 0) begin
        for (i = 0; i < 4; i++) duty[i] = hot;
      end else begin
        duty[$urandom_range(3)] = hot;
      end
    end
    t.duty_front_a = 16'(duty[0]);
    t.duty_front_b = 16'(duty[1]);
    t.duty_rear_a  = 16'(duty[2]);
    t.duty_rear_b  = 16'(duty[3]);
    t.frame_seen   = ($urandom_range(99) < frame_pct);
    return t;
  endfunction

  // Mostly short persistence so that trips come often; extremes now and then.
  function automatic logic [15:0] pick_trip();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom);
      default: return 16'($urandom_range(25, 2));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Transaction tasks
  // ---------------------------------------------------------------------

  // Offer one tick; valid stays high on return so back-to-back ticks need
  // no second assignment in the same step.
  task automatic send_tick(input ffs_tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick       <= t;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    expected_faults.push_back(predict_fault(t));
  endtask

  // Drop valid and wait for every queued fault, then the pipeline tail.
  task automatic wait_drain();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (expected_faults.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write enable stays high across a burst; end_writes lowers it.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_BATTERY_LOW_LEVEL:  model_cfg.battery_low_level  = data[9:0];
      REG_BATTERY_TRIP_TICKS: model_cfg.battery_trip_ticks = data;
      REG_TILT_LIMIT:         model_cfg.tilt_limit         = data[14:0];
      REG_TILT_TRIP_TICKS:    model_cfg.tilt_trip_ticks    = data;
      REG_DUTY_HIGH_LEVEL:    model_cfg.duty_high_level    = data;
      REG_DUTY_TRIP_TICKS:    model_cfg.duty_trip_ticks    = data;
      REG_SIGNAL_LOSS_TICKS:  model_cfg.signal_loss_ticks  = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic randomize_config();
    logic [15:0] v;
    case ($urandom_range(7))
      0: v = 16'd0;
      1: v = 16'd1023;
      2: v = 16'hFFFF;   // only the low 10 bits stick
      default: v = 16'($urandom_range(900, 40));
    endcase
    write_reg(REG_BATTERY_LOW_LEVEL, v);
    write_reg(REG_BATTERY_TRIP_TICKS, pick_trip());
    case ($urandom_range(7))
      0: v = 16'd0;
      1: v = 16'd32767;
      2: v = 16'hFFFF;   // only the low 15 bits stick
      default: v = 16'($urandom_range(20000, 500));
    endcase
    write_reg(REG_TILT_LIMIT, v);
    write_reg(REG_TILT_TRIP_TICKS, pick_trip());
    case ($urandom_range(7))
      0: v = 16'd0;
      1: v = 16'hFFFF;
      default: v = 16'($urandom_range(64000, 1000));
    endcase
    write_reg(REG_DUTY_HIGH_LEVEL, v);
    write_reg(REG_DUTY_TRIP_TICKS, pick_trip());
    write_reg(REG_SIGNAL_LOSS_TICKS, pick_trip());
    end_writes();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset configuration: field extremes, then enough tilted ticks to trip.
  task automatic test_reset_defaults();
    int i;
    send_tick(mk_tick(1023, 0, 0, 0, 0, 0, 0, 1'b1));
    send_tick(mk_tick(0, -32768, 32767, 65535, 0, 0, 0, 1'b0));
    for (i = 0; i < 9; i++) begin
      send_tick(mk_tick(500, (i % 2 == 0) ? -32768 : 18000, -18000,
                        9899, 9899, 9899, 9900, 1'b0));
    end
    send_tick(mk_tick(1023, 0, 0, 0, 0, 0, 0, 1'b1));
  endtask

  // Trip points of zero, fault priority, and a frame that arrives while an
  // earlier check trips and must be consumed later.
  task automatic test_trip_zero();
    wait_drain();
    write_reg(REG_BATTERY_LOW_LEVEL, 16'd1023);
    write_reg(REG_BATTERY_TRIP_TICKS, 16'd0);
    write_reg(REG_TILT_LIMIT, 16'd0);
    write_reg(REG_TILT_TRIP_TICKS, 16'd0);
    write_reg(REG_DUTY_HIGH_LEVEL, 16'd0);
    write_reg(REG_DUTY_TRIP_TICKS, 16'd0);
    write_reg(REG_SIGNAL_LOSS_TICKS, 16'd0);
    end_writes();
    send_tick(mk_tick(0, 100, 0, 0, 0, 0, 0, 1'b1));     // battery; frame held
    send_tick(mk_tick(1023, 100, 0, 0, 0, 0, 0, 1'b0));  // tilt
    send_tick(mk_tick(1023, 0, 0, 0, 0, 0, 0, 1'b0));    // duty level 0 always hot
    wait_drain();
    write_reg(REG_TILT_LIMIT, 16'd32767);
    write_reg(REG_DUTY_HIGH_LEVEL, 16'hFFFF);
    end_writes();
    send_tick(mk_tick(1023, -32768, 0, 0, 0, 0, 0, 1'b0));  // 32768 > 32767
    send_tick(mk_tick(1023, 32767, -32767, 65534, 65534, 65534, 65534, 1'b0));
    send_tick(mk_tick(1023, 0, 0, 0, 0, 0, 65535, 1'b0));
    send_tick(mk_tick(1023, 0, 0, 0, 0, 0, 0, 1'b0));       // signal lost
    send_tick(mk_tick(1023, 0, 0, 0, 0, 0, 0, 1'b1));
  endtask

  // Oversized data keeps only the register width; index 7 is dropped.
  task automatic test_register_truncation();
    wait_drain();
    write_reg(REG_BATTERY_LOW_LEVEL, 16'hFFFF);
    write_reg(REG_TILT_LIMIT, 16'hFFFF);
    write_reg(REG_BATTERY_TRIP_TICKS, 16'd2);
    write_reg(REG_TILT_TRIP_TICKS, 16'd1);
    write_reg(REG_UNUSED, 16'd0);
    end_writes();
    send_tick(mk_tick(1022, 0, 0, 0, 0, 0, 0, 1'b1));
    send_tick(mk_tick(1022, -32768, 0, 0, 0, 0, 0, 1'b0));
    send_tick(mk_tick(1023, -32768, 0, 0, 0, 0, 0, 1'b0));
    send_tick(mk_tick(1023, 32767, 32767, 0, 0, 0, 0, 1'b1));
  endtask

  // Blocks of episodes under a fresh configuration: each episode holds a
  // set of conditions for a while so that the counters build up and trip.
  task automatic test_random_traffic(input int n);
    int sent;
    int block_len;
    int run_len;
    bit low;
    bit tilt;
    bit sat;
    int frame_pct;
    sent = 0;
    while (sent < n) begin
      wait_drain();
      randomize_config();
      block_len = $urandom_range(140, 60);
      while (block_len > 0 && sent < n) begin
        run_len = $urandom_range(30, 1);
        low  = ($urandom_range(3) == 0);
        tilt = ($urandom_range(3) == 0);
        sat  = ($urandom_range(3) == 0);
        case ($urandom_range(3))
          0: frame_pct = 0;
          1: frame_pct = 100;
          default: frame_pct = $urandom_range(100, 0);
        endcase
        repeat (run_len) begin
          send_tick(random_tick(low, tilt, sat, frame_pct));
          sent++;
          block_len--;
        end
      end
    end
  endtask

  // Receiver holds off while ticks keep coming, so the block fills and
  // stalls its input; then the sender pauses until all results are back.
  task automatic test_backpressure();
    wait_drain();
    hold_req_id <= hold_req_id + 1;
    repeat (40) begin
      send_tick(random_tick($urandom_range(3) == 0, $urandom_range(3) == 0,
                            $urandom_range(3) == 0, 50));
    end
    wait_drain();
  endtask

  // Trip points of 65535: a short run of low battery ticks and of ticks
  // without a frame builds the counters without reaching a fault.
  task automatic test_long_trip_points();
    wait_drain();
    write_reg(REG_BATTERY_LOW_LEVEL, 16'd1023);
    write_reg(REG_BATTERY_TRIP_TICKS, 16'hFFFF);
    write_reg(REG_TILT_LIMIT, 16'd32767);
    write_reg(REG_TILT_TRIP_TICKS, 16'd1);
    write_reg(REG_DUTY_HIGH_LEVEL, 16'hFFFF);
    write_reg(REG_DUTY_TRIP_TICKS, 16'd1);
    write_reg(REG_SIGNAL_LOSS_TICKS, 16'hFFFF);
    end_writes();
    repeat (20) send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 1'b0));
    repeat (20) send_tick(mk_tick(1023, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(mk_tick(1023, 0, 0, 0, 0, 0, 0, 1'b1));
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: stall pattern, hold-off and result check
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_req_id != hold_seen_id) begin
      hold_seen_id <= hold_req_id;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("%0t mismatch: %s", $time, msg);
  endtask

  // A result transaction completes at this edge: compare with the oldest
  // predicted fault.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_faults.size() == 0) begin
        note_failure($sformatf("result code %0d enable %0d with no tick pending",
                               result.fault_code, result.motors_enabled));
      end else begin
        want = expected_faults.pop_front();
        if (result.fault_code !== want.fault_code)
          note_failure($sformatf("fault_code expected %0d actual %0d",
                                 want.fault_code, result.fault_code));
        if (result.motors_enabled !== want.motors_enabled)
          note_failure($sformatf("motors_enabled expected %0d actual %0d",
                                 want.motors_enabled, result.motors_enabled));
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction.
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((tick_valid && !tick_stall) || (result_valid && !result_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_top: errors");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------

  initial begin
    model_cfg.battery_low_level  = RstBatteryLowLevel;
    model_cfg.battery_trip_ticks = RstBatteryTripTicks;
    model_cfg.tilt_limit         = RstTiltLimit;
    model_cfg.tilt_trip_ticks    = RstTiltTripTicks;
    model_cfg.duty_high_level    = RstDutyHighLevel;
    model_cfg.duty_trip_ticks    = RstDutyTripTicks;
    model_cfg.signal_loss_ticks  = RstSignalLossTicks;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // phase 1: sender mostly busy, receiver mostly stalled
    send_idle_pct = 23;
    recv_idle_pct = 85;
    test_reset_defaults();
    test_trip_zero();
    test_register_truncation();
    test_random_traffic(600);

    // phase 2: the other way round
    wait_drain();
    send_idle_pct = 85;
    recv_idle_pct = 23;
    test_random_traffic(550);

    // phase 3: full rate on both sides
    wait_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_traffic(500);
    test_long_trip_points();

    wait_drain();
    if (fail_count == 0 && expected_faults.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: flight_fault_supervisor.f
src/ffs_pkg.sv
src/ffs_eval.sv
src/flight_fault_supervisor.sv
bench/tb_top.sv
